>>> rtl/window_neighborhood_counter_defines.svh
// assertion macros for the window neighbourhood counter
// used by the top level only, no other dependencies
`ifndef WINDOW_NEIGHBORHOOD_COUNTER_DEFINES_SVH
`define WINDOW_NEIGHBORHOOD_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS
`define WNC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define WNC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define WNC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define WNC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> rtl/wnc_pkg.sv
// shared types, widths and register indexes of the window neighbourhood counter
// no dependencies
`timescale 1ns / 1ps

package wnc_pkg;

   localparam int POS_W      = 31;
   localparam int IDX_W      = 13;
   localparam int CNT_W      = 14;
   localparam int WCNT_W     = 5;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam int MAX_GENES_DEF   = 8192;
   localparam int MAX_WINDOWS_DEF = 16;

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WINDOW   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_STEP  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_COUNT = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_GENE_TOTAL   = CSR_IDX_W'(3);

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE,
      ST_WINS,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

endpackage

>>> rtl/window_neighborhood_counter.sv
// window neighbourhood counter: position table, window scan and result output
// depends on wnc_pkg and window_neighborhood_counter_defines.svh
`timescale 1ns / 1ps
`include "window_neighborhood_counter_defines.svh"

// Usage
// req_ channel: mode 0 writes req_position into the table at req_index, no
// result. mode 1 queries start index s = req_index.
// csr_ channel: always ready; index 0 min window, 1 step, 2 window count,
// 3 gene total. Write only while the block is idle.
// rsp_ channel: one word per window size, rsp_last on the final one.
// A query reads the start position, builds the N window limits, scans the
// table from s+1 to total-1 (one memory read a cycle, all window lanes
// compared in parallel), passes a drain step, then outputs N words. The
// single read port of the position memory sets the scan length. A start
// with nothing after it skips the scan.
// The output register holds a word while rsp_ready is low; the block then
// waits, and takes the next request once the last word is registered.
// Reset clears control state and the configuration registers; table contents
// are undefined until written, and no clearing pass is run.
module window_neighborhood_counter #(
   parameter int MAX_GENES   = wnc_pkg::MAX_GENES_DEF,
   parameter int MAX_WINDOWS = wnc_pkg::MAX_WINDOWS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_mode,
   input  logic [wnc_pkg::IDX_W-1:0]        req_index,
   input  logic [wnc_pkg::POS_W-1:0]        req_position,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [wnc_pkg::POS_W-1:0]        rsp_window_size,
   output logic [wnc_pkg::IDX_W-1:0]        rsp_start_index,
   output logic [wnc_pkg::CNT_W-1:0]        rsp_neighbour_count,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wnc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wnc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import wnc_pkg::*;

   localparam int ADDR_W = $clog2(MAX_GENES);
   localparam int TOT_W  = $clog2(MAX_GENES + 1);
   localparam int KW     = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
   localparam int KC_W   = $clog2(MAX_WINDOWS + 1);
   localparam int CMP_W  = ((TOT_W > IDX_W) ? TOT_W : IDX_W) + 1;
   localparam int WC_W   = ((KC_W > WCNT_W) ? KC_W : WCNT_W) + 1;
   localparam int DIF_W  = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

   // configuration registers
   logic [POS_W-1:0]  min_window_ff, window_step_ff;
   logic [WCNT_W-1:0] window_count_ff;
   logic [CNT_W-1:0]  gene_total_ff;

   state_type state_ff, state_in;

   logic [KW-1:0]     k_ff, k_in;
   logic [ADDR_W-1:0] e_ff, e_in;
   logic [IDX_W-1:0]  s_ff;
   logic [TOT_W-1:0]  total_ff;
   logic [KC_W-1:0]   cnt_ff;
   logic              skip_ff;
   logic [POS_W-1:0]  base_ff;
   logic [POS_W-1:0]  acc_ff, acc_in;
   logic              scan_vld_ff;
   logic [ADDR_W-1:0] scan_e_ff;

   logic [POS_W-1:0]  win_ff  [MAX_WINDOWS];
   logic [POS_W:0]    lim_ff  [MAX_WINDOWS];
   logic [ADDR_W-1:0] best_ff [MAX_WINDOWS];

   logic [POS_W-1:0]  table_mem [MAX_GENES];
   logic [POS_W-1:0]  rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;

   logic              rsp_valid_ff;
   logic [POS_W-1:0]  rsp_window_size_ff;
   logic [IDX_W-1:0]  rsp_start_index_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic              rsp_last_ff;

   logic              req_take, query_take, load_rsp, k_last;
   logic [CMP_W-1:0]  gt_ext, total_eff, s_inc;
   logic [WC_W-1:0]   wc_ext, cnt_eff;
   logic [POS_W:0]    step_sum, pos_inc;
   logic [DIF_W-1:0]  count_full;
   logic [ADDR_W-1:0] best_sel;

   // configuration port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_window_ff   <= POS_W'(1);
         window_step_ff  <= POS_W'(1);
         window_count_ff <= WCNT_W'(1);
         gene_total_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MIN_WINDOW:   min_window_ff   <= csr_data[POS_W-1:0];
            CSR_WINDOW_STEP:  window_step_ff  <= csr_data[POS_W-1:0];
            CSR_WINDOW_COUNT: window_count_ff <= csr_data[WCNT_W-1:0];
            CSR_GENE_TOTAL:   gene_total_ff   <= csr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // effective limits of a query
   always_comb begin
      gt_ext    = CMP_W'(gene_total_ff);
      total_eff = (gt_ext > CMP_W'(MAX_GENES)) ? CMP_W'(MAX_GENES) : gt_ext;
      s_inc     = CMP_W'(req_index) + CMP_W'(1);
      wc_ext    = WC_W'(window_count_ff);
      if (wc_ext == '0) begin
         cnt_eff = WC_W'(1);
      end else if (wc_ext > WC_W'(MAX_WINDOWS)) begin
         cnt_eff = WC_W'(MAX_WINDOWS);
      end else begin
         cnt_eff = wc_ext;
      end
   end

   assign req_take   = req_valid && req_ready;
   assign query_take = req_take && (req_mode == MODE_QUERY);
   assign wr_en      = req_take && (req_mode == MODE_LOAD)
                       && (CMP_W'(req_index) < CMP_W'(MAX_GENES));
   assign k_last     = (({1'b0, k_ff} + (KW+1)'(1)) == (KW+1)'(cnt_ff));
   assign load_rsp   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (query_take) state_in = ST_BASE;
         ST_BASE:  state_in = ST_WINS;
         ST_WINS:  if (k_last) state_in = skip_ff ? ST_EMIT : ST_SCAN;
         ST_SCAN:  if (e_ff == ADDR_W'(total_ff - TOT_W'(1))) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_EMIT;
         ST_EMIT:  if (load_rsp && k_last) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rd_addr   = (state_ff == ST_IDLE) ? ADDR_W'(req_index) : e_ff;
      k_in      = k_ff;
      e_in      = e_ff;
      step_sum  = {1'b0, acc_ff} + {1'b0, window_step_ff};
      acc_in    = acc_ff;
      case (state_ff)
         ST_IDLE: begin
            k_in   = '0;
            e_in   = ADDR_W'(s_inc);
            acc_in = min_window_ff;
         end
         ST_WINS: begin
            k_in   = k_last ? '0 : k_ff + KW'(1);
            acc_in = step_sum[POS_W] ? POS_MAX : step_sum[POS_W-1:0];
         end
         ST_SCAN: e_in = e_ff + ADDR_W'(1);
         ST_EMIT: if (load_rsp) k_in = k_last ? '0 : k_ff + KW'(1);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         k_ff        <= '0;
         scan_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         k_ff        <= k_in;
         scan_vld_ff <= (state_ff == ST_SCAN);
      end
   end

   // query context
   always_ff @(posedge clock) begin
      e_ff      <= e_in;
      acc_ff    <= acc_in;
      scan_e_ff <= e_ff;
      if (query_take) begin
         s_ff     <= req_index;
         total_ff <= TOT_W'(total_eff);
         cnt_ff   <= KC_W'(cnt_eff);
         skip_ff  <= (s_inc >= total_eff);
      end
      if (state_ff == ST_BASE) begin
         base_ff <= rd_data_ff;
      end
   end

   // position memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[ADDR_W'(req_index)] <= req_position;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   // window lanes: limits, then largest fitting index per lane
   assign pos_inc = {1'b0, rd_data_ff} + (POS_W+1)'(1);

   always_ff @(posedge clock) begin
      if (state_ff == ST_WINS) begin
         win_ff[k_ff] <= acc_ff;
         lim_ff[k_ff] <= {1'b0, base_ff} + {1'b0, acc_ff};
      end
      for (int i = 0; i < MAX_WINDOWS; i++) begin
         if (query_take) begin
            best_ff[i] <= '0;
         end else if (scan_vld_ff && (pos_inc <= lim_ff[i])) begin
            best_ff[i] <= scan_e_ff;
         end
      end
   end

   // result register
   assign best_sel   = best_ff[k_ff];
   assign count_full = DIF_W'(best_sel) - DIF_W'(s_ff) + DIF_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_window_size_ff <= win_ff[k_ff];
         rsp_start_index_ff <= s_ff;
         rsp_count_ff       <= (best_sel == '0) ? '0 : CNT_W'(count_full);
         rsp_last_ff        <= k_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_window_size     = rsp_window_size_ff;
   assign rsp_start_index     = rsp_start_index_ff;
   assign rsp_neighbour_count = rsp_count_ff;
   assign rsp_last            = rsp_last_ff;

   // checks
   `WNC_ASSERT_NEXT(a_scan_feeds_lanes, clock, reset, state_ff == ST_SCAN, scan_vld_ff, "scan read lost")
   `WNC_ASSERT_NOW(a_emit_in_range, clock, reset, state_ff == ST_EMIT, (KW+1)'(k_ff) < (KW+1)'(cnt_ff), "window cursor past count")
   `WNC_ASSERT_NEXT(a_last_ends_query, clock, reset, load_rsp && k_last, state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff, "last word not closing query")

endmodule
